[rtl/htfd_pkg.sv]
// shared types, constants and crc function for the humidity/temperature frame decoder
`default_nettype none

package htfd_pkg;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [2:0]  POS_STATUS  = 3'd0;
    localparam logic [2:0]  POS_CRC     = 3'd6;
    localparam logic [9:0]  HUM_SCALE   = 10'd1000;
    localparam logic [10:0] TEMP_SCALE  = 11'd2000;
    localparam logic [11:0] TEMP_OFFSET = 12'd500;

    typedef struct packed {
        logic        crc_ok;
        logic [19:0] raw_humidity;
        logic [19:0] raw_temperature;
    } t_frame;

    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/htfd_if.sv]
// byte input and decoded result channel interfaces
`default_nettype none

interface htfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface htfd_out_if;
    logic               valid;
    logic               ready;
    logic               crc_ok;
    logic [19:0]        raw_humidity;
    logic [19:0]        raw_temperature;
    logic [9:0]         humidity_tenths;
    logic signed [11:0] temperature_tenths;

    modport source (output valid, output crc_ok, output raw_humidity, output raw_temperature,
                    output humidity_tenths, output temperature_tenths, input ready);
    modport sink   (input valid, input crc_ok, input raw_humidity, input raw_temperature,
                    input humidity_tenths, input temperature_tenths, output ready);
endinterface

`default_nettype wire

[rtl/htfd_front.sv]
// front end: byte position tracking, crc-8 and payload collection
`default_nettype none

module htfd_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    htfd_in_if.sink              i_in,
    input  wire logic            i_q_full,
    output htfd_pkg::t_frame     o_q_data,
    output logic                 o_q_push
);

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [39:0] r_payload, n_payload;
    logic [2:0]  pos_eff;
    logic [7:0]  crc_eff;
    logic [39:0] payload_eff;
    logic        accept;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        if (i_in.frame_start) begin
            pos_eff     = htfd_pkg::POS_STATUS;
            crc_eff     = htfd_pkg::CRC_INIT;
            payload_eff = '0;
        end else begin
            pos_eff     = r_pos;
            crc_eff     = r_crc;
            payload_eff = r_payload;
        end
    end

    always_comb begin
        n_pos     = htfd_pkg::POS_STATUS;
        n_crc     = htfd_pkg::CRC_INIT;
        n_payload = '0;
        o_q_push  = 1'b0;
        if (pos_eff < htfd_pkg::POS_CRC) begin
            n_pos     = pos_eff + 3'd1;
            n_crc     = htfd_pkg::crc_fold(crc_eff, i_in.data_byte);
            n_payload = (pos_eff != htfd_pkg::POS_STATUS)
                        ? {payload_eff[31:0], i_in.data_byte} : payload_eff;
        end else if (pos_eff == htfd_pkg::POS_CRC) begin
            o_q_push = accept;
        end
        o_q_data.crc_ok          = (crc_eff == i_in.data_byte);
        o_q_data.raw_humidity    = payload_eff[39:20];
        o_q_data.raw_temperature = payload_eff[19:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= htfd_pkg::POS_STATUS;
            r_crc     <= htfd_pkg::CRC_INIT;
            r_payload <= '0;
        end else if (accept) begin
            r_pos     <= n_pos;
            r_crc     <= n_crc;
            r_payload <= n_payload;
        end
    end

endmodule

`default_nettype wire

[rtl/htfd_fifo.sv]
// short frame queue between front and back end
`default_nettype none

module htfd_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire htfd_pkg::t_frame  i_push_data,
    output logic                   o_full,
    output logic                   o_pop_valid,
    input  wire logic              i_pop_ready,
    output htfd_pkg::t_frame       o_pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    htfd_pkg::t_frame r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          pop;

    assign o_full      = (r_cnt == FULL);
    assign o_pop_valid = (r_cnt != '0);
    assign pop         = o_pop_valid && i_pop_ready;
    assign o_pop_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PW'(1);
            end
            unique if (i_push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end else begin
                r_cnt <= r_cnt;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/htfd_back.sv]
// back end: scaling multiplies and result output register
`default_nettype none

module htfd_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire htfd_pkg::t_frame  i_frame,
    htfd_out_if.source             o_out
);

    logic             r_s1_valid;
    htfd_pkg::t_frame r_s1_frame;
    logic [29:0]      r_s1_hprod;
    logic [30:0]      r_s1_tprod;
    logic             r_o_valid;
    logic             s2_load;
    logic [11:0]      n_temp;

    assign s2_load = r_s1_valid && (!r_o_valid || o_out.ready);
    assign o_ready = !r_s1_valid || s2_load;
    assign n_temp  = {1'b0, r_s1_tprod[30:20]} - htfd_pkg::TEMP_OFFSET;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (!r_o_valid || o_out.ready) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1_frame <= i_frame;
            r_s1_hprod <= 30'(i_frame.raw_humidity) * 30'(htfd_pkg::HUM_SCALE);
            r_s1_tprod <= 31'(i_frame.raw_temperature) * 31'(htfd_pkg::TEMP_SCALE);
        end
        if (s2_load) begin
            o_out.crc_ok             <= r_s1_frame.crc_ok;
            o_out.raw_humidity       <= r_s1_frame.raw_humidity;
            o_out.raw_temperature    <= r_s1_frame.raw_temperature;
            o_out.humidity_tenths    <= r_s1_hprod[29:20];
            o_out.temperature_tenths <= $signed(n_temp);
        end
    end

    assign o_out.valid = r_o_valid;

endmodule

`default_nettype wire

[rtl/humidity_temp_frame_decoder_unit.sv]
// top level of the humidity/temperature measurement frame decoder
//
// channel  dir  handshake     payload
// i_in     in   valid/ready   data_byte[7:0], frame_start
// o_out    out  valid/ready   crc_ok, raw_humidity[19:0], raw_temperature[19:0],
//                             humidity_tenths[9:0], temperature_tenths[11:0] signed
//
// one byte accepted per cycle while the frame queue is not full; crc-8 folds a whole byte at a time
// a result travels from its crc byte transfer through the queue, the multiply stage and the output register
// i_in stalls only while the frame queue is full and a stalled o_out holds its result
// synchronous active-low reset returns the byte position to zero and empties the pipeline
`default_nettype none

module humidity_temp_frame_decoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    htfd_in_if.sink    i_in,
    htfd_out_if.source o_out
);

    htfd_pkg::t_frame push_data;
    htfd_pkg::t_frame pop_data;
    logic             push;
    logic             full;
    logic             pop_valid;
    logic             pop_ready;

    htfd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (full),
        .o_q_data (push_data),
        .o_q_push (push)
    );

    htfd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .o_pop_valid (pop_valid),
        .i_pop_ready (pop_ready),
        .o_pop_data  (pop_data)
    );

    htfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pop_valid),
        .o_ready (pop_ready),
        .i_frame (pop_data),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

[rtl/htfd_checker.sv]
// port-level assertions for the frame decoder and their bind
`default_nettype none

module htfd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_out_crc_ok,
    input wire logic [19:0] i_out_raw_humidity,
    input wire logic [19:0] i_out_raw_temperature,
    input wire logic [9:0]  i_out_humidity_tenths,
    input wire logic [11:0] i_out_temperature_tenths
);

    logic [29:0] hum_prod;
    logic [30:0] temp_prod;
    logic [11:0] temp_exp;

    assign hum_prod  = 30'(i_out_raw_humidity) * 30'd1000;
    assign temp_prod = 31'(i_out_raw_temperature) * 31'd2000;
    assign temp_exp  = {1'b0, temp_prod[30:20]} - 12'd500;

    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_crc_ok)
            && $stable(i_out_raw_humidity) && $stable(i_out_raw_temperature))
        else $error("stalled result changed");

    a_hum_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_humidity_tenths == hum_prod[29:20])
        else $error("humidity tenths disagree with raw count");

    a_temp_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_temperature_tenths == temp_exp)
        else $error("temperature tenths disagree with raw count");

endmodule

bind humidity_temp_frame_decoder_unit htfd_checker u_htfd_checker (
    .i_clk                    (i_clk),
    .i_rst_n                  (i_rst_n),
    .i_out_valid              (o_out.valid),
    .i_out_ready              (o_out.ready),
    .i_out_crc_ok             (o_out.crc_ok),
    .i_out_raw_humidity       (o_out.raw_humidity),
    .i_out_raw_temperature    (o_out.raw_temperature),
    .i_out_humidity_tenths    (o_out.humidity_tenths),
    .i_out_temperature_tenths (o_out.temperature_tenths)
);

`default_nettype wire

[tb/humidity_temp_frame_decoder_unit_checker.sv]
// checker for the frame decoder: predicts decoded readings from byte transfers and compares them
module humidity_temp_frame_decoder_unit_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_frame_start,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_crc_ok,
    input  logic [19:0]        i_raw_humidity,
    input  logic [19:0]        i_raw_temperature,
    input  logic [9:0]         i_humidity_tenths,
    input  logic signed [11:0] i_temperature_tenths,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               crc_ok;
        logic [19:0]        raw_hum;
        logic [19:0]        raw_temp;
        logic [9:0]         hum_tenths;
        logic signed [11:0] temp_tenths;
    } t_reading;

    t_reading   readings_q[$];
    logic [2:0] frame_pos;
    logic [7:0] frame_crc;
    logic [39:0] payload;

    // one data bit at a time, msb first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            if (c[7] ^ b[i]) begin
                c = {c[6:0], 1'b0} ^ htfd_pkg::CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    task automatic restart_frame();
        frame_pos = htfd_pkg::POS_STATUS;
        frame_crc = htfd_pkg::CRC_INIT;
        payload   = '0;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic start);
        t_reading    r;
        logic [63:0] prod;
        if (start) begin
            restart_frame();
        end
        if (frame_pos < htfd_pkg::POS_CRC) begin
            frame_crc = crc8_update(frame_crc, b);
            if (frame_pos != htfd_pkg::POS_STATUS) begin
                payload = {payload[31:0], b};
            end
            frame_pos = frame_pos + 3'd1;
        end else if (frame_pos == htfd_pkg::POS_CRC) begin
            r.crc_ok      = (frame_crc == b);
            r.raw_hum     = payload[39:20];
            r.raw_temp    = payload[19:0];
            prod          = 64'(r.raw_hum) * 64'(htfd_pkg::HUM_SCALE);
            r.hum_tenths  = 10'(prod >> 20);
            prod          = 64'(r.raw_temp) * 64'(htfd_pkg::TEMP_SCALE);
            r.temp_tenths = 12'(prod >> 20) - htfd_pkg::TEMP_OFFSET;
            readings_q.push_back(r);
            restart_frame();
        end else begin
            restart_frame();
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            o_errors++;
            $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            restart_frame();
            readings_q.delete();
            o_errors = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (readings_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected reading, expected none got crc_ok=%0b hum=%h temp=%h",
                             $time, i_crc_ok, i_raw_humidity, i_raw_temperature);
                end else begin
                    want = readings_q.pop_front();
                    check_field("crc_ok", int'(want.crc_ok), int'(i_crc_ok));
                    check_field("raw_humidity", int'(want.raw_hum), int'(i_raw_humidity));
                    check_field("raw_temperature", int'(want.raw_temp), int'(i_raw_temperature));
                    check_field("humidity_tenths", int'(want.hum_tenths), int'(i_humidity_tenths));
                    check_field("temperature_tenths", int'(want.temp_tenths),
                                int'(i_temperature_tenths));
                end
            end
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_data_byte, i_frame_start);
            end
        end
        o_pending = readings_q.size();
    end

endmodule

[tb/humidity_temp_frame_decoder_unit_tb.sv]
// testbench top for the frame decoder: clock, reset, byte stimulus, output stalls and verdict
module humidity_temp_frame_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 2000;
    localparam int QUIET_FROM  = 1700;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   items_sent = 0;
    int   cycles = 0;
    int   ready_hold = 0;
    bit   gaps_on = 1'b1;

    htfd_in_if  byte_ch ();
    htfd_out_if reading_ch ();

    humidity_temp_frame_decoder_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (reading_ch)
    );

    humidity_temp_frame_decoder_unit_checker u_chk (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (byte_ch.valid),
        .i_in_ready           (byte_ch.ready),
        .i_data_byte          (byte_ch.data_byte),
        .i_frame_start        (byte_ch.frame_start),
        .i_out_valid          (reading_ch.valid),
        .i_out_ready          (reading_ch.ready),
        .i_crc_ok             (reading_ch.crc_ok),
        .i_raw_humidity       (reading_ch.raw_humidity),
        .i_raw_temperature    (reading_ch.raw_temperature),
        .i_humidity_tenths    (reading_ch.humidity_tenths),
        .i_temperature_tenths (reading_ch.temperature_tenths),
        .o_errors             (errors),
        .o_pending            (pending)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // output stalls in bursts
    initial begin
        logic take;
        reading_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (ready_hold > 0) begin
                ready_hold--;
                take = 1'b0;
            end else if (gaps_on && $urandom_range(0, 9) == 0) begin
                ready_hold = $urandom_range(0, 11);
                take = 1'b0;
            end else begin
                take = 1'b1;
            end
            reading_ch.ready = take;
        end
    end

    function automatic logic [7:0] body_crc(input logic [47:0] body);
        logic [7:0] c;
        c = htfd_pkg::CRC_INIT;
        for (int i = 47; i >= 0; i--) begin
            c = (c[7] ^ body[i]) ? ({c[6:0], 1'b0} ^ htfd_pkg::CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic start);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            byte_ch.valid       = 1'b0;
            byte_ch.data_byte   = 8'($urandom);
            byte_ch.frame_start = 1'($urandom);
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        byte_ch.valid       = 1'b1;
        byte_ch.data_byte   = b;
        byte_ch.frame_start = start;
        do @(posedge i_clk); while (!byte_ch.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // status byte first, then five data bytes, then the crc byte
    task automatic send_frame(input logic [47:0] body, input logic start, input logic [7:0] crc);
        for (int k = 0; k < 6; k++) begin
            send_byte(body[47 - 8 * k -: 8], (k == 0) ? start : 1'b0);
        end
        send_byte(crc, 1'b0);
    endtask

    initial begin
        logic [47:0] body;
        logic [7:0]  crc;
        int          kind;
        int          n;
        bit          drained;
        drained             = 1'b0;
        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = 8'h00;
        byte_ch.frame_start = 1'b0;
        i_rst_n             = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // lowest readings, then highest readings with status byte taken without the flag
        send_frame(48'h0, 1'b1, body_crc(48'h0));
        send_frame({48{1'b1}}, 1'b0, body_crc({48{1'b1}}));
        // partial frame abandoned by a new frame start, which then carries a bad crc
        send_byte(8'h1c, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        body = 48'h1c_8000_0800_00;
        send_frame(body, 1'b1, body_crc(body) ^ 8'h01);

        while (items_sent < ITEM_TARGET) begin
            gaps_on = (items_sent < 600) || (items_sent >= 900 && items_sent < QUIET_FROM);
            kind = $urandom_range(0, 19);
            if (kind < 14) begin
                for (int k = 0; k < 6; k++) begin
                    case ($urandom_range(0, 7))
                        0:       body[47 - 8 * k -: 8] = 8'h00;
                        1:       body[47 - 8 * k -: 8] = 8'hff;
                        default: body[47 - 8 * k -: 8] = 8'($urandom);
                    endcase
                end
                crc = body_crc(body);
                if ($urandom_range(0, 3) == 0) begin
                    crc = 8'($urandom);
                end
                send_frame(body, $urandom_range(0, 3) != 0, crc);
                if (!drained && items_sent >= 1000) begin
                    byte_ch.valid = 1'b0;
                    while (pending != 0) @(negedge i_clk);
                    drained = 1'b1;
                end
            end else if (kind < 17) begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++) begin
                    send_byte(8'($urandom), k == 0);
                end
            end else begin
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++) begin
                    send_byte(8'($urandom), $urandom_range(0, 3) == 0);
                end
            end
        end

        byte_ch.valid = 1'b0;
        gaps_on       = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
rtl/htfd_pkg.sv
rtl/htfd_if.sv
rtl/htfd_front.sv
rtl/htfd_fifo.sv
rtl/htfd_back.sv
rtl/humidity_temp_frame_decoder_unit.sv
rtl/htfd_checker.sv
tb/humidity_temp_frame_decoder_unit_checker.sv
tb/humidity_temp_frame_decoder_unit_tb.sv
